// File: rtl/clws_pkg.sv
package clws_pkg;

  localparam int MAG_W     = 32;
  localparam int INT_W_DEF = 32;
  localparam int QDEPTH    = 2;
  localparam int CFG_IDX_W = 2;

  // request codes
  localparam logic [2:0] CMD_RAW    = 3'd0;
  localparam logic [2:0] CMD_CHAR   = 3'd1;
  localparam logic [2:0] CMD_CURSOR = 3'd2;
  localparam logic [2:0] CMD_INT    = 3'd3;
  localparam logic [2:0] CMD_INIT   = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_SET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_CTRL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_SET  = 2'd3;

  localparam logic [7:0] RST_FUNCTION_SET = 8'h38;
  localparam logic [7:0] RST_DISPLAY_CTRL = 8'h0E;
  localparam logic [7:0] RST_CLEAR        = 8'h01;
  localparam logic [7:0] RST_ADDRESS_SET  = 8'h80;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // job kinds in the queue
  localparam logic JOB_BYTES = 1'b0;
  localparam logic JOB_INT   = 1'b1;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [1:0]         row;
    logic [5:0]         col;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_data;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic             kind;
    logic             rs;
    logic [1:0]       count;   // bytes to send, 1..3
    logic [23:0]      bytes;   // first byte in the top lane
    logic             neg;
    logic [MAG_W-1:0] mag;
  } job_t;

  function automatic int num_width(input int w);
    return (w < MAG_W) ? w : MAG_W;
  endfunction

  // decimal digits of 2**w - 1 (1233/4096 ~ log10 2)
  function automatic int dec_digits(input int w);
    return ((w * 1233) >> 12) + 1;
  endfunction

  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    unique case (row)
      2'd0: off = 8'h00;
      2'd1: off = 8'h40;
      2'd2: off = 8'h10;
      2'd3: off = 8'h50;
    endcase
    return off;
  endfunction

endpackage

// File: rtl/clws_front.sv
module clws_front import clws_pkg::*; #(
  parameter int INT_WIDTH = INT_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output job_t                 q_job
);

  localparam int NUM_W = num_width(INT_WIDTH);

  logic [7:0] function_set_code;
  logic [7:0] display_control_code;
  logic [7:0] clear_code;
  logic [7:0] address_set_code;

  logic             known;
  logic [7:0]       addr;
  logic [NUM_W-1:0] num;
  logic             neg;
  logic [NUM_W-1:0] mag;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      function_set_code    <= RST_FUNCTION_SET;
      display_control_code <= RST_DISPLAY_CTRL;
      clear_code           <= RST_CLEAR;
      address_set_code     <= RST_ADDRESS_SET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FUNCTION_SET: function_set_code    <= cfg_data;
        CFG_DISPLAY_CTRL: display_control_code <= cfg_data;
        CFG_CLEAR:        clear_code           <= cfg_data;
        CFG_ADDRESS_SET:  address_set_code     <= cfg_data;
      endcase
    end
  end

  // magnitude taken unsigned, so the most negative value survives
  assign num  = in_item.value[NUM_W-1:0];
  assign neg  = num[NUM_W-1];
  assign mag  = neg ? (~num + 1'b1) : num;
  assign addr = {2'b00, in_item.col} + row_offset(in_item.row);

  always_comb begin
    known        = 1'b1;
    q_job.kind   = JOB_BYTES;
    q_job.rs     = 1'b0;
    q_job.count  = 2'd1;
    q_job.bytes  = {in_item.value[7:0], 16'h0000};
    q_job.neg    = neg;
    q_job.mag    = MAG_W'(mag);
    unique case (in_item.command)
      CMD_RAW: ;
      CMD_CHAR: q_job.rs = 1'b1;
      CMD_CURSOR: q_job.bytes = {addr | address_set_code, 16'h0000};
      CMD_INT: begin
        q_job.kind = JOB_INT;
        q_job.rs   = 1'b1;
      end
      CMD_INIT: begin
        q_job.count = 2'd3;
        q_job.bytes = {function_set_code, display_control_code, clear_code};
      end
      CMD_CLEAR: q_job.bytes = {clear_code, 16'h0000};
      default: known = 1'b0;  // unused codes are dropped
    endcase
  end

  assign q_push = in_valid && !in_stall && known;

endmodule

// File: rtl/clws_queue.sv
module clws_queue import clws_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(QDEPTH));
  assign valid   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/clws_back.sv
module clws_back import clws_pkg::*; #(
  parameter int INT_WIDTH = INT_W_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int NUM_W  = num_width(INT_WIDTH);
  localparam int ND     = dec_digits(NUM_W);
  localparam int BCD_W  = 4 * ND;
  localparam int BIT_CW = $clog2(NUM_W + 1);
  localparam int DIG_CW = $clog2(ND + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BYTES = 3'd1;
  localparam logic [2:0] ST_CONV  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0]        state;
  logic              rs;
  logic [1:0]        cnt;
  logic [23:0]       bytes;
  logic              neg;
  logic [NUM_W-1:0]  bin;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic [BIT_CW-1:0] bit_cnt;
  logic [DIG_CW-1:0] dig_left;
  logic              leading;

  logic              can_emit;
  logic              skip;
  logic              emit;
  logic [3:0]        cur_digit;
  out_item_t         emit_item;

  assign can_emit  = !out_valid || !out_stall;
  assign cur_digit = bcd[BCD_W-1 -: 4];
  assign skip      = leading && (cur_digit == 4'd0) && (dig_left != DIG_CW'(1));
  assign q_pop     = (state == ST_IDLE) && q_valid;

  // double dabble: add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < ND; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3 : bcd[4*d +: 4];
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_item = '{reg_select: rs, bus_data: bytes[23:16], last: (cnt == 2'd1)};
    unique case (state)
      ST_BYTES: emit = can_emit;
      ST_SIGN: begin
        emit      = can_emit;
        emit_item = '{reg_select: 1'b1, bus_data: CHAR_MINUS, last: 1'b0};
      end
      ST_DIGIT: begin
        emit      = can_emit && !skip;
        emit_item = '{reg_select: 1'b1, bus_data: CHAR_ZERO | {4'h0, cur_digit},
                      last: (dig_left == DIG_CW'(1))};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= (q_job.kind == JOB_INT) ? ST_CONV : ST_BYTES;
          end
        end
        ST_BYTES: begin
          if (can_emit && cnt == 2'd1) begin
            state <= ST_IDLE;
          end
        end
        ST_CONV: begin
          if (bit_cnt == BIT_CW'(1)) begin
            state <= neg ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (can_emit) begin
            state <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if ((skip || can_emit) && dig_left == DIG_CW'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= emit_item;
    end
    unique case (state)
      ST_IDLE: begin
        rs      <= q_job.rs;
        cnt     <= q_job.count;
        bytes   <= q_job.bytes;
        neg     <= q_job.neg;
        bin     <= q_job.mag[NUM_W-1:0];
        bcd     <= '0;
        bit_cnt <= BIT_CW'(NUM_W);
      end
      ST_BYTES: begin
        if (can_emit) begin
          bytes <= {bytes[15:0], 8'h00};
          cnt   <= cnt - 2'd1;
        end
      end
      ST_CONV: begin
        bcd      <= {bcd_adj[BCD_W-2:0], bin[NUM_W-1]};
        bin      <= {bin[NUM_W-2:0], 1'b0};
        bit_cnt  <= bit_cnt - 1'b1;
        dig_left <= DIG_CW'(ND);
        leading  <= 1'b1;
      end
      ST_SIGN: ;
      ST_DIGIT: begin
        if (skip || can_emit) begin
          bcd      <= {bcd[BCD_W-5:0], 4'h0};
          dig_left <= dig_left - 1'b1;
          if (!skip) begin
            leading <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE) && q_valid)
    else $error("queue popped outside idle");

  a_last_ends_job: assert property (@(posedge clk) disable iff (rst)
    emit && emit_item.last |=> state == ST_IDLE)
    else $error("last write did not end the job");

  a_sign_needs_neg: assert property (@(posedge clk) disable iff (rst)
    state == ST_SIGN |-> neg)
    else $error("sign emitted for non-negative value");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIGIT |-> dig_left != '0)
    else $error("digit state with no digits left");

  a_conv_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_CONV |-> bit_cnt != '0)
    else $error("conversion ran past its width");

endmodule

// File: rtl/char_lcd_write_sequencer.sv
// Byte request: held in the queue, loaded into the back end, then one bus write per cycle
// while the output is not stalled. Integer request: bit-serial binary-to-BCD conversion of
// up to 32 bits, then an optional minus sign and the decimal digits, leading zeros skipped.
// Throughput: the back end runs one request at a time; a 2-deep queue lets the input side
// keep accepting while a job is in progress. Synchronous active-high reset empties the
// queue and output register and reloads the LCD command codes with their defaults.
module char_lcd_write_sequencer import clws_pkg::*; #(
  parameter int INT_WIDTH = INT_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  job_t push_job;
  job_t head_job;

  clws_front #(.INT_WIDTH(INT_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  clws_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_job)
  );

  clws_back #(.INT_WIDTH(INT_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
